/* rtl/sacl_pkg.sv */
// Package for the LRU tag store: sizes, address split, command codes, queue entry type.
// No dependencies.
package sacl_pkg;
  localparam int NUM_SETS   = 1024;
  localparam int NUM_WAYS   = 8;
  localparam int LINE_BYTES = 64;
  localparam int ADDR_BITS  = 32;

  localparam int OFF_BITS  = $clog2(LINE_BYTES + 1) - 1;
  localparam int SET_BITS  = $clog2(NUM_SETS + 1) - 1;
  localparam int SETW      = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int TAG_LSB   = OFF_BITS + SET_BITS;
  localparam int TAG_BITS  = ADDR_BITS - TAG_LSB;
  localparam int WAY_BITS  = $clog2(NUM_WAYS);
  localparam int RANK_BITS = $clog2(NUM_WAYS);
  localparam int NSETS_P2  = 1 << SET_BITS;
  localparam int ROW_BITS  = NUM_WAYS * (1 + TAG_BITS + RANK_BITS);

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_FETCH = 2'd1,
    CMD_INVAL = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  typedef struct packed {
    logic                clear;
    logic                inval;
    logic [SETW-1:0]     set;
    logic [TAG_BITS-1:0] tag;
  } req_t;
endpackage

/* rtl/set_assoc_cache_lru_tags_top.sv */
// Top level of the LRU tag store: front queue plus back lookup/update engine.
// Depends on sacl_pkg, sacl_front, sacl_back.
//
//  channel | valid / ready       | payload
//  --------+---------------------+---------------------------------------------
//  in      | valid_i / ready_o   | cmd_i, address_i
//  out     | valid_o / ready_i   | hit_o, way_o, read_total_o, hit_total_o, miss_total_o
//
// A read, fetch or invalidate goes through the back end in steps: one set-memory
// read, one compare/update with write-back, one result step (ready_i low stretches it).
// Clear gives its result at once and then sweeps the set memory, one set a
// cycle; the next lookup starts only once the sweep is done and the clear
// result has been taken. The first sweep runs after reset, before any
// transaction is processed. A two-entry queue decouples input from lookup.
module set_assoc_cache_lru_tags_top import sacl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] address_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic        hit_o,
  output logic [2:0]  way_o,
  output logic [31:0] read_total_o,
  output logic [31:0] hit_total_o,
  output logic [31:0] miss_total_o
);
  logic req_valid, req_ready;
  req_t req;

  sacl_front u_front (
    .clk_i, .rst_ni, .valid_i, .ready_o, .cmd_i, .address_i,
    .req_valid_o(req_valid), .req_ready_i(req_ready), .req_o(req)
  );

  sacl_back u_back (
    .clk_i, .rst_ni,
    .req_valid_i(req_valid), .req_ready_o(req_ready), .req_i(req),
    .valid_o, .ready_i, .hit_o, .way_o, .read_total_o, .hit_total_o, .miss_total_o
  );
endmodule

/* rtl/sacl_front.sv */
// Front end: accepts transactions, splits address into set and tag, two-entry queue.
// Depends on sacl_pkg.
module sacl_front import sacl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] address_i,
  output logic        req_valid_o,
  input  logic        req_ready_i,
  output req_t        req_o
);
  req_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic [ADDR_BITS-1:0] a;
  req_t       r;
  logic       push, pop;

  always_comb begin
    a = ADDR_BITS'(address_i);
    r.clear = (cmd_i == CMD_CLEAR);
    r.inval = (cmd_i == CMD_INVAL);
    r.set   = (SET_BITS > 0) ? SETW'(a >> OFF_BITS) : '0;
    r.tag   = TAG_BITS'(a >> TAG_LSB);
  end

  assign ready_o     = (cnt_q != 2'd2);
  assign push        = valid_i && ready_o;
  assign req_valid_o = (cnt_q != 2'd0);
  assign pop         = req_valid_o && req_ready_i;
  assign req_o       = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end
endmodule

/* rtl/sacl_back.sv */
// Back end: set memory read, hit test, LRU update, write-back, counters, clear sweep.
// Depends on sacl_pkg.
module sacl_back import sacl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  req_t        req_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic        hit_o,
  output logic [2:0]  way_o,
  output logic [31:0] read_total_o,
  output logic [31:0] hit_total_o,
  output logic [31:0] miss_total_o
);
  typedef enum logic [3:0] {
    ST_SWEEP = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_LOOK  = 4'b0100,
    ST_OUT   = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [ROW_BITS-1:0] mem [NSETS_P2];
  logic [ROW_BITS-1:0] rd_q;
  logic [SETW-1:0]     ptr_q;
  req_t                cur_q;
  logic [31:0]         rc_q, hc_q, mc_q;
  logic                hit_q;
  logic [2:0]          way_q;
  // clear result shown while sweep runs (output valid from sweep start)
  logic                clr_pend_q;
  logic                take;

  logic                 v   [NUM_WAYS];
  logic [TAG_BITS-1:0]  tg  [NUM_WAYS];
  logic [RANK_BITS-1:0] rk  [NUM_WAYS];
  logic [ROW_BITS-1:0]  wr_row;
  logic                 hit;
  logic [WAY_BITS-1:0]  hw, vic, best, sel;
  logic                 vfound;
  logic [RANK_BITS-1:0] sr;
  logic                 nv  [NUM_WAYS];
  logic [TAG_BITS-1:0]  ntg [NUM_WAYS];
  logic [RANK_BITS-1:0] nrk [NUM_WAYS];

  localparam int EW = 1 + TAG_BITS + RANK_BITS;

  always_comb begin
    hit = 1'b0; hw = '0; vfound = 1'b0; vic = '0; best = '0;
    for (int i = 0; i < NUM_WAYS; i++) begin
      v[i]  = rd_q[i*EW + TAG_BITS + RANK_BITS];
      tg[i] = rd_q[i*EW + RANK_BITS +: TAG_BITS];
      rk[i] = rd_q[i*EW +: RANK_BITS];
    end
    for (int i = NUM_WAYS - 1; i >= 0; i--) begin
      if (v[i] && tg[i] == cur_q.tag) begin
        hit = 1'b1; hw = WAY_BITS'(i);
      end
      if (!v[i] || rk[i] == '0) begin
        vfound = 1'b1; vic = WAY_BITS'(i);
      end
    end
    for (int i = 1; i < NUM_WAYS; i++)
      if (rk[i] < rk[best]) best = WAY_BITS'(i);
    sel = hit ? hw : (vfound ? vic : best);
    sr  = rk[sel];
    for (int i = 0; i < NUM_WAYS; i++) begin
      nv[i] = v[i]; ntg[i] = tg[i]; nrk[i] = rk[i];
    end
    if (cur_q.inval) begin
      if (hit) begin
        for (int i = 0; i < NUM_WAYS; i++)
          if (v[i] && rk[i] < sr) nrk[i] = rk[i] + 1'b1;
        nrk[sel] = '0; nv[sel] = 1'b0;
      end
    end else begin
      for (int i = 0; i < NUM_WAYS; i++)
        if (v[i] && rk[i] > sr) nrk[i] = rk[i] - 1'b1;
      nrk[sel] = RANK_BITS'(NUM_WAYS - 1);
      if (!hit) begin
        nv[sel] = 1'b1; ntg[sel] = cur_q.tag;
      end
    end
    for (int i = 0; i < NUM_WAYS; i++)
      wr_row[i*EW +: EW] = {nv[i], ntg[i], nrk[i]};
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_SWEEP: if (ptr_q == SETW'(NSETS_P2 - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (take) state_d = req_i.clear ? ST_SWEEP : ST_LOOK;
      ST_LOOK:  state_d = ST_OUT;
      ST_OUT:   if (ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // a clear result still waiting holds back the next lookup
  assign req_ready_o = (state_q == ST_IDLE) && !clr_pend_q;
  assign take        = req_valid_i && req_ready_o;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SWEEP) mem[ptr_q] <= '0;
    else if (state_q == ST_LOOK) mem[cur_q.set] <= wr_row;
    if (state_q == ST_IDLE) begin
      rd_q  <= mem[req_i.set];
      cur_q <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SWEEP; ptr_q <= '0;
      rc_q <= '0; hc_q <= '0; mc_q <= '0;
      hit_q <= 1'b0; way_q <= '0; clr_pend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_SWEEP) ptr_q <= ptr_q + 1'b1;
      if (take && req_i.clear) begin
        rc_q <= '0; hc_q <= '0; mc_q <= '0;
        hit_q <= 1'b0; way_q <= '0; clr_pend_q <= 1'b1;
        ptr_q <= '0;
      end
      if (clr_pend_q && valid_o && ready_i) clr_pend_q <= 1'b0;
      if (state_q == ST_LOOK) begin
        hit_q <= hit;
        way_q <= (cur_q.inval && !hit) ? 3'd0 : 3'(sel);
        if (!cur_q.inval) begin
          if (rc_q != '1) rc_q <= rc_q + 1'b1;
          if (hit  && hc_q != '1) hc_q <= hc_q + 1'b1;
          if (!hit && mc_q != '1) mc_q <= mc_q + 1'b1;
        end
      end
    end
  end

  assign valid_o      = (state_q == ST_OUT) || clr_pend_q;
  assign hit_o        = hit_q;
  assign way_o        = way_q;
  assign read_total_o = rc_q;
  assign hit_total_o  = hc_q;
  assign miss_total_o = mc_q;
endmodule

/* tb/tb_set_assoc_cache_lru_tags_top.sv */
// Self-checking testbench for the LRU tag store top level.
// Depends on sacl_pkg and set_assoc_cache_lru_tags_top; needs nothing else.
module tb_set_assoc_cache_lru_tags_top;
  import sacl_pkg::*;

  localparam int LINES = NUM_SETS * NUM_WAYS;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        ready_o;
  logic [1:0]  cmd_i = 2'd0;
  logic [31:0] address_i = 32'd0;
  logic        valid_o;
  logic        ready_i = 1'b0;
  logic        hit_o;
  logic [2:0]  way_o;
  logic [31:0] read_total_o, hit_total_o, miss_total_o;

  // one lookup outcome as the block reports it
  typedef struct {
    logic        hit;
    logic [2:0]  way;
    logic [31:0] reads;
    logic [31:0] hits;
    logic [31:0] misses;
  } lookup_t;

  lookup_t lookup_q[$];   // outcomes still owed by the block

  // shadow tag store
  logic                 shadow_valid [LINES];
  logic [TAG_BITS-1:0]  shadow_tag   [LINES];
  logic [RANK_BITS-1:0] shadow_rank  [LINES];
  logic [31:0]          cnt_reads, cnt_hits, cnt_misses;

  bit failed = 1'b0;
  int hold_off = 0;       // cycles the receiver still has to stall
  bit calm_rx = 1'b0;     // receiver always ready when set, unless a hold-off is running

  always #4 clk_i = ~clk_i;

  set_assoc_cache_lru_tags_top dut (.*);

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic void clear_shadow();
    for (int i = 0; i < LINES; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_tag[i]   = '0;
      shadow_rank[i]  = '0;
    end
    cnt_reads = '0; cnt_hits = '0; cnt_misses = '0;
  endfunction

  // Move way w of the set at base to most recent.
  function automatic void to_front(int base, int w);
    logic [RANK_BITS-1:0] r;
    r = shadow_rank[base + w];
    for (int i = 0; i < NUM_WAYS; i++)
      if (shadow_valid[base + i] && shadow_rank[base + i] > r)
        shadow_rank[base + i]--;
    shadow_rank[base + w] = RANK_BITS'(NUM_WAYS - 1);
  endfunction

  // Work out the outcome of one transaction and update the shadow store.
  function automatic lookup_t predict_lookup(cmd_e cmd, logic [31:0] addr);
    lookup_t res;
    int set, base, found, victim, best;
    logic [TAG_BITS-1:0] tag;
    logic [RANK_BITS-1:0] r;
    bit hit;
    set   = (SET_BITS > 0) ? int'((addr >> OFF_BITS) & (NSETS_P2 - 1)) : 0;
    tag   = TAG_BITS'(addr >> TAG_LSB);
    base  = set * NUM_WAYS;
    hit   = 1'b0;
    found = 0;
    if (cmd == CMD_CLEAR) begin
      clear_shadow();
    end else begin
      for (int i = 0; i < NUM_WAYS; i++)
        if (!hit && shadow_valid[base + i] && shadow_tag[base + i] == tag) begin
          hit = 1'b1;
          found = i;
        end
      if (cmd == CMD_INVAL) begin
        if (hit) begin
          // demote: older valid ways move up one rank, the dropped way goes to rank 0
          r = shadow_rank[base + found];
          for (int i = 0; i < NUM_WAYS; i++)
            if (shadow_valid[base + i] && shadow_rank[base + i] < r)
              shadow_rank[base + i]++;
          shadow_rank[base + found]  = '0;
          shadow_valid[base + found] = 1'b0;
        end
      end else if (hit) begin
        to_front(base, found);
        cnt_reads = sat_inc(cnt_reads);
        cnt_hits  = sat_inc(cnt_hits);
      end else begin
        victim = NUM_WAYS;
        best   = 0;
        for (int i = 0; i < NUM_WAYS; i++) begin
          if (victim == NUM_WAYS) begin
            if (!shadow_valid[base + i] || shadow_rank[base + i] == 0)
              victim = i;
            else if (shadow_rank[base + i] < shadow_rank[base + best])
              best = i;
          end
        end
        if (victim == NUM_WAYS) victim = best;
        shadow_valid[base + victim] = 1'b1;
        shadow_tag[base + victim]   = tag;
        to_front(base, victim);
        found = victim;
        cnt_reads  = sat_inc(cnt_reads);
        cnt_misses = sat_inc(cnt_misses);
      end
    end
    res.hit    = hit;
    res.way    = 3'(found);
    res.reads  = cnt_reads;
    res.hits   = cnt_hits;
    res.misses = cnt_misses;
    return res;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one transaction; returns at the falling edge after it is taken.
  task automatic send_txn(cmd_e cmd, logic [31:0] addr, bit no_gap = 1'b0);
    int gap;
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    valid_i   <= 1'b1;
    cmd_i     <= cmd;
    address_i <= addr;
    do @(posedge clk_i); while (!ready_o);
    lookup_q.push_back(predict_lookup(cmd, addr));
    @(negedge clk_i);
  endtask

  task automatic go_idle();
    valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    go_idle();
    while (lookup_q.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [31:0] mk_addr(int tag, int set);
    return (32'(tag) << TAG_LSB) | (32'(set) << OFF_BITS) | 32'($urandom_range(0, LINE_BYTES - 1));
  endfunction

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      ready_i  <= 1'b0;
      hold_off <= hold_off - 1;
    end else if (calm_rx) begin
      ready_i <= 1'b1;
    end else begin
      ready_i <= (pick_gap() == 0);
    end
  end

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    lookup_t exp_r;
    if (rst_ni && valid_o && ready_i) begin
      if (lookup_q.size() == 0) begin
        $error("result with nothing expected: hit=%0d way=%0d", hit_o, way_o);
        failed = 1'b1;
      end else begin
        exp_r = lookup_q.pop_front();
        if (hit_o !== exp_r.hit) begin
          $error("hit: expected %0d, got %0d", exp_r.hit, hit_o); failed = 1'b1;
        end
        if (way_o !== exp_r.way) begin
          $error("way: expected %0d, got %0d", exp_r.way, way_o); failed = 1'b1;
        end
        if (read_total_o !== exp_r.reads) begin
          $error("read_total: expected %0d, got %0d", exp_r.reads, read_total_o);
          failed = 1'b1;
        end
        if (hit_total_o !== exp_r.hits) begin
          $error("hit_total: expected %0d, got %0d", exp_r.hits, hit_total_o);
          failed = 1'b1;
        end
        if (miss_total_o !== exp_r.misses) begin
          $error("miss_total: expected %0d, got %0d", exp_r.misses, miss_total_o);
          failed = 1'b1;
        end
      end
    end
  end

  // Directed: corners of the address, both read kinds, fill past capacity,
  // invalidate hit and miss, clear.
  task automatic test_directed();
    send_txn(CMD_READ,  32'h0000_0000);
    send_txn(CMD_FETCH, 32'h0000_0000);
    send_txn(CMD_READ,  32'hFFFF_FFFF);
    send_txn(CMD_FETCH, 32'hFFFF_FFC0);
    for (int t = 1; t <= NUM_WAYS + 2; t++) send_txn(CMD_READ, mk_addr(t, 5));
    send_txn(CMD_READ,  mk_addr(4, 5));
    send_txn(CMD_INVAL, mk_addr(4, 5));
    send_txn(CMD_INVAL, mk_addr(4, 5));
    send_txn(CMD_INVAL, 32'h1234_5678);
    send_txn(CMD_READ,  mk_addr(20, 5));
    send_txn(CMD_CLEAR, 32'hA5A5_A5A5);
    send_txn(CMD_READ,  32'hFFFF_FFFF);
    send_txn(CMD_FETCH, 32'hFFFF_FFFF);
    wait_drained();
  endtask

  // Random traffic on a few hot sets with a small tag pool so hits, evictions
  // and invalidates all happen; some fully random addresses as noise.
  task automatic test_random(int n);
    int p, set;
    cmd_e c;
    logic [31:0] a;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(0, 199);
      if (p < 2)        c = CMD_CLEAR;
      else if (p < 90)  c = CMD_READ;
      else if (p < 140) c = CMD_FETCH;
      else              c = CMD_INVAL;
      if ($urandom_range(0, 9) == 0) begin
        a = $urandom();
      end else begin
        set = $urandom_range(0, 3) * (NSETS_P2 / 4) + $urandom_range(0, 1);
        a = mk_addr($urandom_range(0, 11), set);
      end
      send_txn(c, a);
    end
    wait_drained();
  endtask

  // Receiver stalls for a long time while the sender keeps going, then the
  // sender pauses until everything has come back; then back-to-back fetches with a ready receiver.
  task automatic test_backpressure();
    hold_off = 300;
    for (int i = 0; i < 24; i++) send_txn(CMD_READ, mk_addr($urandom_range(0, 9), 7), 1'b1);
    wait_drained();
    calm_rx = 1'b1;
    for (int i = 0; i < 30; i++) send_txn(CMD_FETCH, mk_addr($urandom_range(0, 9), 7), 1'b1);
    calm_rx = 1'b0;
    wait_drained();
  endtask

  initial begin
    clear_shadow();
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_backpressure();
    test_random(1500);
    repeat (50) @(negedge clk_i);
    if (lookup_q.size() != 0) begin
      $error("%0d results never arrived", lookup_q.size());
      failed = 1'b1;
    end
    if (!failed)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #(8 * 2_000_000);
    $display("== FAIL ==");
    $finish;
  end
endmodule

/* filelist.f */
rtl/sacl_pkg.sv
rtl/sacl_front.sv
rtl/sacl_back.sv
rtl/set_assoc_cache_lru_tags_top.sv
tb/tb_set_assoc_cache_lru_tags_top.sv
